[rtl/great_circle_distance_assert.svh]
// ---------------------------------------------------------------------------
// Great-circle distance assertion macros
// Shared property forms for the checks at the end of the top module.
// ---------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define GCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("great_circle_distance: assertion failed");

// Condition that must never hold outside reset.
`define GCD_ASSERT_NEVER(label, cond) \
  `GCD_ASSERT_IMP(label, 1'b1, !(cond))

`endif

[rtl/gcd_pkg.sv]
// ---------------------------------------------------------------------------
// Great-circle distance package
// Field widths, fixed-point constants and shared types of the distance pipe.
// ---------------------------------------------------------------------------
package gcd_pkg;

  // Field widths of one item and one result.
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 23;

  // Default number of fraction bits of an angle in degrees.
  localparam int ANGLE_FRACTION_BITS_DEF = 16;

  // Width of the signed angle fed to a phase converter.
  localparam int PH_IN_W = 26;

  // Q30 fixed point: 1.0 is 2^30.
  typedef logic [30:0] q30_t;

  localparam q30_t        Q30_ONE  = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // Taylor series divisors of the sine, applied in Horner order.
  localparam int HORNER_STEPS = 7;
  localparam int unsigned HORNER_DIVS [HORNER_STEPS] = '{210, 156, 110, 72, 42, 20, 6};

  // Register stages of one sine unit.
  localparam int SINE_LAT = 25;

  // Bits of the arcsine search, from bit 30 down to bit 0.
  localparam int SEARCH_STEPS = 31;

  // Earth radius in 1/256 km and the saturation value of the result.
  localparam logic [20:0]       DIST_SCALE = 21'd1630976;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;

  // Values that ride along the sine pipeline.
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [1:0]  quad;
  } sine_ctx_t;

endpackage

[rtl/great_circle_distance.sv]
// ---------------------------------------------------------------------------
// great_circle_distance: haversine distance between two points, 1/256 km.
// Throughput: one item per cycle outside reset; the 31 sine-square units of the
// arcsine search set most of the depth. Synchronous reset clears all valid bits.
// ---------------------------------------------------------------------------
`include "great_circle_distance_assert.svh"

module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [LAT_W-1:0] first_latitude,
  input  logic signed [LON_W-1:0] first_longitude,
  input  logic signed [LAT_W-1:0] second_latitude,
  input  logic signed [LON_W-1:0] second_longitude,
  output logic                    done,
  output logic [DIST_W-1:0]       distance
);

  localparam int HALF_SHIFT = 31 - ANGLE_FRACTION_BITS;
  localparam int FULL_SHIFT = 32 - ANGLE_FRACTION_BITS;
  localparam int DIV_W      = PH_IN_W + FULL_SHIFT - 2;
  localparam int PHASE_LAT  = (DIV_W + 3) / 4 + 2;
  localparam int TOTAL_LAT  = 1 + PHASE_LAT + SINE_LAT + 3
                              + SEARCH_STEPS * (SINE_LAT + 1) + 2;

  // The pipe never stalls; items are refused only during reset.
  assign busy = rst;

  // Input stage: coordinate differences.
  logic                    in_vld;
  logic signed [LAT_W-1:0] lat1_r;
  logic signed [LAT_W-1:0] lat2_r;
  logic signed [LAT_W:0]   dlat_r;
  logic signed [LON_W:0]   dlon_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    lat1_r <= first_latitude;
    lat2_r <= second_latitude;
    dlat_r <= (LAT_W+1)'(second_latitude) - (LAT_W+1)'(first_latitude);
    dlon_r <= (LON_W+1)'(second_longitude) - (LON_W+1)'(first_longitude);
  end

  // Phases: half angles of the differences, full angles of the latitudes.
  logic        ph_vld;
  logic [31:0] ph_dlat;
  logic [31:0] ph_dlon;
  logic [31:0] ph_lat1;
  logic [31:0] ph_lat2;

  gcd_phase #(.SHIFT(HALF_SHIFT), .QW(DIV_W)) u_ph_dlat (
    .clk(clk), .rst(rst), .in_valid(in_vld), .angle(PH_IN_W'(dlat_r)),
    .out_valid(ph_vld), .phase(ph_dlat)
  );

  gcd_phase #(.SHIFT(HALF_SHIFT), .QW(DIV_W)) u_ph_dlon (
    .clk(clk), .rst(rst), .in_valid(in_vld), .angle(PH_IN_W'(dlon_r)),
    .out_valid(), .phase(ph_dlon)
  );

  gcd_phase #(.SHIFT(FULL_SHIFT), .QW(DIV_W)) u_ph_lat1 (
    .clk(clk), .rst(rst), .in_valid(in_vld), .angle(PH_IN_W'(lat1_r)),
    .out_valid(), .phase(ph_lat1)
  );

  gcd_phase #(.SHIFT(FULL_SHIFT), .QW(DIV_W)) u_ph_lat2 (
    .clk(clk), .rst(rst), .in_valid(in_vld), .angle(PH_IN_W'(lat2_r)),
    .out_valid(), .phase(ph_lat2)
  );

  // Sine squares of the half differences and cosines of the latitudes.
  logic sn_vld;
  q30_t sq_lat;
  q30_t sq_lon;
  q30_t cos1;
  q30_t cos2;
  logic cos1_neg;
  logic cos2_neg;

  gcd_sine #(.TAG_W(1)) u_sn_dlat (
    .clk(clk), .rst(rst), .in_valid(ph_vld), .phase(ph_dlat), .tag_in(1'b0),
    .out_valid(sn_vld), .sine(), .negative(), .sine_sq(sq_lat), .tag_out()
  );

  gcd_sine #(.TAG_W(1)) u_sn_dlon (
    .clk(clk), .rst(rst), .in_valid(ph_vld), .phase(ph_dlon), .tag_in(1'b0),
    .out_valid(), .sine(), .negative(), .sine_sq(sq_lon), .tag_out()
  );

  gcd_sine #(.TAG_W(1)) u_cs_lat1 (
    .clk(clk), .rst(rst), .in_valid(ph_vld), .phase(ph_lat1 + 32'(Q30_ONE)),
    .tag_in(1'b0), .out_valid(), .sine(cos1), .negative(cos1_neg), .sine_sq(),
    .tag_out()
  );

  gcd_sine #(.TAG_W(1)) u_cs_lat2 (
    .clk(clk), .rst(rst), .in_valid(ph_vld), .phase(ph_lat2 + 32'(Q30_ONE)),
    .tag_in(1'b0), .out_valid(), .sine(cos2), .negative(cos2_neg), .sine_sq(),
    .tag_out()
  );

  // Product of the cosine magnitudes.
  logic [61:0] cc_prod;
  logic        cc_vld;
  q30_t        cc_r;
  logic        cc_neg;
  q30_t        cc_sq_lat;
  q30_t        cc_sq_lon;

  assign cc_prod = 62'(cos1) * 62'(cos2) + 62'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      cc_vld <= 1'b0;
    end else begin
      cc_vld <= sn_vld;
    end
  end

  always_ff @(posedge clk) begin
    cc_r      <= cc_prod[60:30];
    cc_neg    <= cos1_neg ^ cos2_neg;
    cc_sq_lat <= sq_lat;
    cc_sq_lon <= sq_lon;
  end

  // Longitude term.
  logic [61:0] tl_prod;
  logic        tl_vld;
  q30_t        tl_r;
  logic        tl_neg;
  q30_t        tl_sq_lat;

  assign tl_prod = 62'(cc_sq_lon) * 62'(cc_r) + 62'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      tl_vld <= 1'b0;
    end else begin
      tl_vld <= cc_vld;
    end
  end

  always_ff @(posedge clk) begin
    tl_r      <= tl_prod[60:30];
    tl_neg    <= cc_neg;
    tl_sq_lat <= cc_sq_lat;
  end

  // Sum for a, clamped to the range 0 to 1.
  logic signed [32:0] a_sum;
  q30_t               a_next;
  logic               a_vld;
  q30_t               a_r;

  always_comb begin
    if (tl_neg) begin
      a_sum = 33'(tl_sq_lat) - 33'(tl_r);
    end else begin
      a_sum = 33'(tl_sq_lat) + 33'(tl_r);
    end
    if (a_sum < 0) begin
      a_next = '0;
    end else if (a_sum > 33'(Q30_ONE)) begin
      a_next = Q30_ONE;
    end else begin
      a_next = a_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= tl_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_next;
  end

  // Arcsine of sqrt(a), one bit of the quarter phase per step.
  logic s_vld [SEARCH_STEPS+1];
  q30_t s_a   [SEARCH_STEPS+1];
  q30_t s_q   [SEARCH_STEPS+1];

  assign s_vld[0] = a_vld;
  assign s_a[0]   = a_r;
  assign s_q[0]   = '0;

  for (genvar k = 0; k < SEARCH_STEPS; k++) begin : g_search
    gcd_step #(
      .BIT(SEARCH_STEPS - 1 - k)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (s_vld[k]),
      .a_in     (s_a[k]),
      .q_in     (s_q[k]),
      .out_valid(s_vld[k+1]),
      .a_out    (s_a[k+1]),
      .q_out    (s_q[k+1])
    );
  end

  // Central angle in Q30 radians.
  logic [62:0] ca_prod;
  logic        ca_vld;
  logic [31:0] ca_r;

  assign ca_prod = 63'(s_q[SEARCH_STEPS]) * 63'(PI_Q30) + 63'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      ca_vld <= 1'b0;
    end else begin
      ca_vld <= s_vld[SEARCH_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    ca_r <= ca_prod[61:30];
  end

  // Scale by the radius and saturate.
  logic [53:0] ds_prod;

  assign ds_prod = 54'(ca_r) * 54'(DIST_SCALE) + 54'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ca_vld;
    end
  end

  always_ff @(posedge clk) begin
    distance <= ds_prod[53] ? DIST_MAX : ds_prod[52:30];
  end

  // Checks on the pipeline.
  `GCD_ASSERT_IMP(a_done_follows_item, done, $past(start && !busy, TOTAL_LAT))
  `GCD_ASSERT_IMP(a_haversine_clamped, a_vld, a_r <= Q30_ONE)
  `GCD_ASSERT_IMP(a_arc_in_quarter, s_vld[SEARCH_STEPS], s_q[SEARCH_STEPS] <= Q30_ONE)

endmodule

[rtl/gcd_phase.sv]
// ---------------------------------------------------------------------------
// Angle to phase converter
// Turns a signed angle in fixed-point degrees into a 32-bit phase (one turn
// is 2^32), rounding half away from zero, by a digit-serial pipelined
// division by 360.
// ---------------------------------------------------------------------------
module gcd_phase
  import gcd_pkg::*;
#(
  parameter int SHIFT = 16,
  parameter int QW    = 40
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [PH_IN_W-1:0] angle,
  output logic                      out_valid,
  output logic [31:0]               phase
);

  localparam int DIGITS = (QW + 3) / 4;
  localparam int PAD_W  = DIGITS * 4;
  localparam int NUM_W  = PH_IN_W + SHIFT + 1;

  // Division by 45 is done a hex digit at a time; 1457 / 2^16 is exact for
  // partial dividends below 720.
  localparam logic [25:0] DIV45_RECIP = 26'd1457;
  localparam logic [9:0]  DIV45       = 10'd45;
  localparam logic [NUM_W-1:0] ROUND_ADD = NUM_W'(180);

  logic [PAD_W-1:0] num_r [DIGITS+1];
  logic [5:0]       rem_r [DIGITS+1];
  logic [31:0]      quo_r [DIGITS+1];
  logic             neg_r [DIGITS+1];
  logic             vld_r [DIGITS+1];

  logic [PH_IN_W-1:0] mag;
  logic [NUM_W-1:0]   numer;

  // Magnitude, scaling and rounding offset; the divide by 8 is a shift.
  always_comb begin
    mag   = angle[PH_IN_W-1] ? PH_IN_W'(-angle) : PH_IN_W'(angle);
    numer = (NUM_W'(mag) << SHIFT) + ROUND_ADD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0] <= PAD_W'(numer >> 3);
    rem_r[0] <= '0;
    quo_r[0] <= '0;
    neg_r[0] <= angle[PH_IN_W-1];
  end

  // One quotient digit per stage.
  for (genvar s = 0; s < DIGITS; s++) begin : g_digit
    logic [9:0]  dv;
    logic [25:0] dprod;
    logic [3:0]  qd;
    logic [9:0]  rem_n;

    always_comb begin
      dv    = {rem_r[s], num_r[s][PAD_W-1 -: 4]};
      dprod = 26'(dv) * DIV45_RECIP;
      qd    = dprod[19:16];
      rem_n = dv - 10'(qd) * DIV45;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      num_r[s+1] <= num_r[s] << 4;
      rem_r[s+1] <= rem_n[5:0];
      quo_r[s+1] <= {quo_r[s][27:0], qd};
      neg_r[s+1] <= neg_r[s];
    end
  end

  // Negative angles wrap modulo one turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    phase <= neg_r[DIGITS] ? (32'd0 - quo_r[DIGITS]) : quo_r[DIGITS];
  end

endmodule

[rtl/gcd_sine.sv]
// ---------------------------------------------------------------------------
// Sine unit
// Pipelined Q30 sine of a 32-bit phase: quarter-wave folding, a Horner
// evaluation of the Taylor series through x^15, and the rounded square.
// ---------------------------------------------------------------------------
module gcd_sine
  import gcd_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [31:0]      phase,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output q30_t             sine,
  output logic             negative,
  output q30_t             sine_sq,
  output logic [TAG_W-1:0] tag_out
);

  // Fold into the first quadrant and scale to Q30 radians.
  logic [30:0] r_fold;
  logic [62:0] p0_prod;

  always_comb begin
    r_fold  = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    p0_prod = 63'(r_fold) * 63'(PI_Q30) + 63'(Q30_ONE);
  end

  logic             p0_vld;
  logic [30:0]      p0_x;
  logic [1:0]       p0_quad;
  logic [TAG_W-1:0] p0_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else begin
      p0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p0_x    <= p0_prod[61:31];
    p0_quad <= phase[31:30];
    p0_tag  <= tag_in;
  end

  // Square of the argument.
  logic [62:0] p1_prod;

  always_comb begin
    p1_prod = 63'(p0_x) * 63'(p0_x) + 63'(Q30_HALF);
  end

  sine_ctx_t        h_ctx [HORNER_STEPS+1];
  q30_t             h_t   [HORNER_STEPS+1];
  logic [TAG_W-1:0] h_tag [HORNER_STEPS+1];
  logic             h_vld [HORNER_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld[0] <= 1'b0;
    end else begin
      h_vld[0] <= p0_vld;
    end
  end

  always_ff @(posedge clk) begin
    h_ctx[0].x    <= p0_x;
    h_ctx[0].x2   <= p1_prod[61:30];
    h_ctx[0].quad <= p0_quad;
    h_t[0]        <= Q30_ONE;
    h_tag[0]      <= p0_tag;
  end

  // Each Horner step: multiply, reciprocal multiply, then correct and
  // subtract from one.
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    localparam logic [32:0] DIVISOR   = 33'(HORNER_DIVS[i]);
    localparam logic [32:0] TWICE     = 33'(2 * HORNER_DIVS[i]);
    localparam logic [32:0] ROUND_ADD = 33'(HORNER_DIVS[i] / 2);
    localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / 64'(HORNER_DIVS[i]));

    logic [62:0]      ma_prod;
    logic [32:0]      ma_n;
    logic             a_vld;
    sine_ctx_t        a_ctx;
    logic [TAG_W-1:0] a_tag;
    logic [32:0]      a_n;
    logic [63:0]      mb_prod;
    logic             b_vld;
    sine_ctx_t        b_ctx;
    logic [TAG_W-1:0] b_tag;
    logic [32:0]      b_n;
    logic [31:0]      b_q0;
    logic [32:0]      mc_rem;
    logic [31:0]      mc_q;
    q30_t             mc_t;

    always_comb begin
      ma_prod = 63'(h_ctx[i].x2) * 63'(h_t[i]) + 63'(Q30_HALF);
      ma_n    = 33'(ma_prod[61:30]) + ROUND_ADD;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
        b_vld <= 1'b0;
      end else begin
        a_vld <= h_vld[i];
        b_vld <= a_vld;
      end
    end

    always_ff @(posedge clk) begin
      a_ctx <= h_ctx[i];
      a_tag <= h_tag[i];
      a_n   <= ma_n;
      b_ctx <= a_ctx;
      b_tag <= a_tag;
      b_n   <= a_n;
      b_q0  <= mb_prod[63:32];
    end

    // The reciprocal estimate is low by at most two.
    always_comb begin
      mb_prod = 64'(a_n) * 64'(RECIP);
      mc_rem  = b_n - 33'(b_q0) * DIVISOR;
      if (mc_rem >= TWICE) begin
        mc_q = b_q0 + 32'd2;
      end else if (mc_rem >= DIVISOR) begin
        mc_q = b_q0 + 32'd1;
      end else begin
        mc_q = b_q0;
      end
      mc_t = (mc_q >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - mc_q);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        h_vld[i+1] <= 1'b0;
      end else begin
        h_vld[i+1] <= b_vld;
      end
    end

    always_ff @(posedge clk) begin
      h_ctx[i+1] <= b_ctx;
      h_t[i+1]   <= mc_t;
      h_tag[i+1] <= b_tag;
    end
  end

  // Final product with the argument, clamped to one.
  logic [62:0] pf_prod;
  q30_t        f_s_next;

  always_comb begin
    pf_prod  = 63'(h_ctx[HORNER_STEPS].x) * 63'(h_t[HORNER_STEPS]) + 63'(Q30_HALF);
    f_s_next = (pf_prod[61:30] > 32'(Q30_ONE)) ? Q30_ONE : pf_prod[60:30];
  end

  logic             f_vld;
  q30_t             f_s;
  logic             f_neg;
  logic [TAG_W-1:0] f_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= h_vld[HORNER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    f_s   <= f_s_next;
    f_neg <= h_ctx[HORNER_STEPS].quad[1] && (f_s_next != '0);
    f_tag <= h_tag[HORNER_STEPS];
  end

  // Rounded square of the sine.
  logic [61:0] pg_prod;

  always_comb begin
    pg_prod = 62'(f_s) * 62'(f_s) + 62'(Q30_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    sine     <= f_s;
    negative <= f_neg;
    sine_sq  <= pg_prod[60:30];
    tag_out  <= f_tag;
  end

endmodule

[rtl/gcd_step.sv]
// ---------------------------------------------------------------------------
// Arcsine search step
// Decides one bit of the quarter phase q: the bit is kept when the squared
// sine of the candidate does not exceed a and the candidate stays within a
// quarter turn.
// ---------------------------------------------------------------------------
module gcd_step
  import gcd_pkg::*;
#(
  parameter int BIT = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  q30_t a_in,
  input  q30_t q_in,
  output logic out_valid,
  output q30_t a_out,
  output q30_t q_out
);

  localparam q30_t BIT_MASK = q30_t'(1) << BIT;

  q30_t        cand;
  logic        sn_vld;
  q30_t        sn_sq;
  logic [61:0] sn_tag;

  assign cand = q_in | BIT_MASK;

  // Squared sine of the candidate; a and q ride along.
  gcd_sine #(
    .TAG_W(62)
  ) u_sine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .phase    ({1'b0, cand}),
    .tag_in   ({a_in, q_in}),
    .out_valid(sn_vld),
    .sine     (),
    .negative (),
    .sine_sq  (sn_sq),
    .tag_out  (sn_tag)
  );

  // Keep or drop the bit.
  q30_t t_a;
  q30_t t_q;
  q30_t t_cand;
  logic take;

  always_comb begin
    t_a    = sn_tag[61:31];
    t_q    = sn_tag[30:0];
    t_cand = t_q | BIT_MASK;
    take   = (t_cand <= Q30_ONE) && (sn_sq <= t_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sn_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_out <= t_a;
    q_out <= take ? t_cand : t_q;
  end

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// Great-circle distance testbench
// Drives coordinate pairs into the haversine pipe with random gaps, predicts
// every distance with a bit-exact fixed-point model and checks each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gcd_pkg::*;

  localparam int FRAC        = ANGLE_FRACTION_BITS_DEF;
  localparam int DRAIN_WAIT  = 900;
  localparam int LAT_RANGE   = 90 << FRAC;
  localparam int LON_RANGE   = 180 << FRAC;
  localparam logic [63:0] ONE_Q30  = 64'h4000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h2000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic signed [LAT_W-1:0] first_latitude = '0;
  logic signed [LON_W-1:0] first_longitude = '0;
  logic signed [LAT_W-1:0] second_latitude = '0;
  logic signed [LON_W-1:0] second_longitude = '0;
  logic [DIST_W-1:0] distance;

  logic [DIST_W-1:0] pending_distances[$];
  int error_count = 0;

  great_circle_distance i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .first_latitude   (first_latitude),
    .first_longitude  (first_longitude),
    .second_latitude  (second_latitude),
    .second_longitude (second_longitude),
    .done             (done),
    .distance         (distance)
  );

  always #6 clk = ~clk;

  // Angle in degrees to a phase where one full turn is 2^32.
  function automatic logic [31:0] to_phase(input longint angle, input int shift);
    logic [63:0] mag;
    logic [63:0] ph;
    mag = (angle < 0) ? 64'(-angle) : 64'(angle);
    ph = ((mag << shift) + 64'd180) / 64'd360;
    if (angle < 0) ph = -ph;
    return ph[31:0];
  endfunction

  // Sine magnitude in Q30 with its sign.
  function automatic logic [63:0] sine_q30(input logic [31:0] ph, output bit neg);
    logic [1:0]  quad;
    logic [63:0] r, x, x2, t, m, d, s;
    quad = ph[31:30];
    r = {34'd0, ph[29:0]};
    if (quad[0]) r = ONE_Q30 - r;
    x = (r * 64'(PI_Q30) + ONE_Q30) >> 31;
    x2 = (x * x + HALF_Q30) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < HORNER_STEPS; i++) begin
      d = 64'(HORNER_DIVS[i]);
      m = (x2 * t + HALF_Q30) >> 30;
      m = (m + d / 2) / d;
      t = (m >= ONE_Q30) ? 64'd0 : ONE_Q30 - m;
    end
    s = (x * t + HALF_Q30) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    neg = (quad >= 2) && (s != 0);
    return s;
  endfunction

  function automatic logic [63:0] sine_sq_q30(input logic [31:0] ph);
    bit ng;
    logic [63:0] s;
    s = sine_q30(ph, ng);
    return (s * s + HALF_Q30) >> 30;
  endfunction

  // Haversine distance in 1/256 km, bit for bit as the pipe computes it.
  function automatic logic [DIST_W-1:0] haversine_distance(
    input logic signed [LAT_W-1:0] lat1, input logic signed [LON_W-1:0] lon1,
    input logic signed [LAT_W-1:0] lat2, input logic signed [LON_W-1:0] lon2);
    bit n1, n2;
    logic [63:0] sq_lat, sq_lon, c1, c2, cc, prod, a, q, cand, c, dist_raw;
    longint a_s;
    sq_lat = sine_sq_q30(to_phase(longint'(lat2) - longint'(lat1), 31 - FRAC));
    sq_lon = sine_sq_q30(to_phase(longint'(lon2) - longint'(lon1), 31 - FRAC));
    c1 = sine_q30(to_phase(longint'(lat1), 32 - FRAC) + 32'h4000_0000, n1);
    c2 = sine_q30(to_phase(longint'(lat2), 32 - FRAC) + 32'h4000_0000, n2);
    cc = (c1 * c2 + HALF_Q30) >> 30;
    prod = (sq_lon * cc + HALF_Q30) >> 30;
    a_s = (n1 != n2) ? longint'(sq_lat) - longint'(prod) : longint'(sq_lat + prod);
    if (a_s < 0) a_s = 0;
    if (a_s > longint'(ONE_Q30)) a_s = longint'(ONE_Q30);
    a = 64'(a_s);
    // Arcsine by a bitwise search on the sine square.
    q = 0;
    for (int b = 30; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      if (cand <= ONE_Q30 && sine_sq_q30(cand[31:0]) <= a) q = cand;
    end
    c = (q * 64'(PI_Q30) + HALF_Q30) >> 30;
    dist_raw = (c * 64'(DIST_SCALE) + HALF_Q30) >> 30;
    if (dist_raw > 64'(DIST_MAX)) dist_raw = 64'(DIST_MAX);
    return dist_raw[DIST_W-1:0];
  endfunction

  // Present one item and hold it until the pipe takes it.
  task automatic send_point_pair(input logic signed [LAT_W-1:0] lat1,
                                 input logic signed [LON_W-1:0] lon1,
                                 input logic signed [LAT_W-1:0] lat2,
                                 input logic signed [LON_W-1:0] lon2);
    bit taken;
    start <= 1'b1;
    first_latitude <= lat1;
    first_longitude <= lon1;
    second_latitude <= lat2;
    second_longitude <= lon2;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    pending_distances.insert(pending_distances.size(),
                             haversine_distance(lat1, lon1, lat2, lon2));
  endtask

  // Idle the sender for a number of cycles.
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  // Field extremes, coincident points, poles and antipodes.
  task automatic test_directed_points();
    send_point_pair(0, 0, 0, 0);
    send_point_pair(LAT_RANGE, LON_RANGE, LAT_RANGE, LON_RANGE);
    send_point_pair(LAT_RANGE, 0, -LAT_RANGE, 0);
    send_point_pair(0, 0, 0, LON_RANGE);
    send_point_pair(0, -LON_RANGE, 0, LON_RANGE);
    send_point_pair(-LAT_RANGE, -LON_RANGE, LAT_RANGE, LON_RANGE);
    send_point_pair(LAT_RANGE, -LON_RANGE, LAT_RANGE, LON_RANGE);
    send_point_pair(0, 0, 0, 1);
    send_point_pair(1, 0, 0, 0);
    send_point_pair(10 << FRAC, 20 << FRAC, -10 << FRAC, -160 << FRAC);
    hold_off(1);
    // Raw field extremes: latitudes beyond a pole give a negative cosine.
    send_point_pair(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
    send_point_pair(24'sh800000, 25'sh1000000, 24'sh800000, 25'sh1000000);
    send_point_pair(24'sh7FFFFF, 0, 0, 0);
    send_point_pair(120 << FRAC, 30 << FRAC, 30 << FRAC, 100 << FRAC);
    send_point_pair(24'shFFFFFF, 25'sh1FFFFFF, 0, 0);
    send_point_pair(-(100 << FRAC), 0, 100 << FRAC, 90 << FRAC);
    hold_off(2);
  endtask

  // Mostly valid coordinates with random gaps; some raw full-width noise.
  task automatic test_random_points(input int count);
    logic signed [LAT_W-1:0] la1, la2;
    logic signed [LON_W-1:0] lo1, lo2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        la1 = LAT_W'($urandom);
        la2 = LAT_W'($urandom);
        lo1 = LON_W'($urandom);
        lo2 = LON_W'($urandom);
      end else begin
        la1 = LAT_W'(int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE);
        la2 = LAT_W'(int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE);
        lo1 = LON_W'(int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE);
        lo2 = LON_W'(int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE);
        if ($urandom_range(0, 7) == 0) begin
          la2 = LAT_W'(int'(la1) + int'($urandom_range(0, 2000)) - 1000);
          lo2 = LON_W'(int'(lo1) + int'($urandom_range(0, 2000)) - 1000);
        end
      end
      send_point_pair(la1, lo1, la2, lo2);
      hold_off((n > 100 && n < 160) ? 0 : random_gap());
    end
  endtask

  // Result checker: done is sampled away from the active clock edge.
  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual distance %0d",
                 $time, distance);
        error_count++;
      end else begin
        if (distance !== pending_distances[0]) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, pending_distances[0], distance);
          error_count++;
        end
        void'(pending_distances.pop_front());
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_points();
    test_random_points(200);
    // Let the pipe empty completely before resuming.
    wait_for_drain();
    @(posedge clk);
    test_random_points(250);
    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_distances.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog for a hung pipe.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
